@@ hw/rtl/mu_law_codec_eight_lane_core_macros.svh @@
// Assertion macros used by the port-level checker mlc_checker.
`ifndef MU_LAW_CODEC_EIGHT_LANE_CORE_MACROS_SVH
`define MU_LAW_CODEC_EIGHT_LANE_CORE_MACROS_SVH

// Checked outside reset only.
`define MLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mlc_pkg.sv @@
// Types and constants of the eight-lane mu-law codec.
package mlc_pkg;

    localparam int LANES           = 8;
    localparam int NUM_LANE_FIELDS = 8;
    localparam int LANE_W          = 16;
    localparam int DATA_W          = NUM_LANE_FIELDS * LANE_W;
    localparam int CODE_W          = 8;
    localparam int SEG_W           = 3;
    localparam int MANT_W          = 4;
    localparam int MAG_W           = 15;
    localparam int BASE_W          = 8;

    localparam logic [MAG_W-1:0]  MAG_MAX    = 15'h7FFF;
    localparam logic [MAG_W-1:0]  ZERO_LIMIT = 15'h000E;
    localparam logic [CODE_W-1:0] ZERO_BYTE  = 8'hFF;
    localparam logic [BASE_W-1:0] BIAS       = 8'h84;

    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    typedef logic [LANE_W-1:0] lane_word_t;
    typedef logic [CODE_W-1:0] code_t;

endpackage

@@ hw/rtl/mlc_lane.sv @@
// One codec lane: mu-law compress or expand of a single 16-bit word.
module mlc_lane
    import mlc_pkg::*;
(
    input  logic       mode,
    input  lane_word_t din,
    output lane_word_t dout
);

    logic               neg;
    lane_word_t         neg_val;
    lane_word_t         mag_full;
    logic [MAG_W-1:0]   mag;
    logic [SEG_W-1:0]   seg;
    logic [SEG_W:0]     shift;
    logic [MAG_W-1:0]   q;
    logic               is_zero;
    code_t              code;

    code_t              c;
    logic [BASE_W-1:0]  base;
    lane_word_t         dmag;
    lane_word_t         dval;

    // compress
    always_comb
    begin
        neg      = din[LANE_W-1];
        neg_val  = LANE_W'(~din + lane_word_t'(1));
        mag_full = neg ? neg_val : din;
        // -32768 saturates rather than wrapping
        if (mag_full[LANE_W-1])
        begin
            mag = MAG_MAX;
        end
        else
        begin
            mag = mag_full[MAG_W-1:0];
        end
        seg = '0;
        for (int i = 8; i < MAG_W; i++)
        begin
            if (mag[i])
            begin
                seg = SEG_W'(i - 7);
            end
        end
        if (seg == '0)
        begin
            shift = (SEG_W+1)'(4);
        end
        else
        begin
            shift = {1'b0, seg} + (SEG_W+1)'(3);
        end
        q       = mag >> shift;
        is_zero = (seg == '0) && (q <= ZERO_LIMIT);
        code    = is_zero ? ZERO_BYTE : {neg, seg, q[MANT_W-1:0]};
    end

    // expand
    always_comb
    begin
        c    = din[CODE_W-1:0];
        base = {1'b0, c[MANT_W-1:0], 3'b000} + BIAS;
        dmag = lane_word_t'(base) << c[6:4];
        if (c == ZERO_BYTE)
        begin
            dval = '0;
        end
        else if (c[CODE_W-1])
        begin
            dval = LANE_W'(~dmag + lane_word_t'(1));
        end
        else
        begin
            dval = dmag;
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_COMPRESS:   dout = {{(LANE_W-CODE_W){1'b0}}, code};
            MODE_DECOMPRESS: dout = dval;
            default:         dout = '0;
        endcase
    end

endmodule

@@ hw/rtl/mu_law_codec_eight_lane_core.sv @@
// Top level of the eight-lane mu-law codec: input register, lanes, result register.
//
//  port group  dir  payload
//  s_axis      in   tdata: 8 x 16-bit lane words, tuser: mode
//  m_axis      out  tdata: 8 x 16-bit lane words
//
// One transfer per cycle sustained while m_axis_tready stays high; a transfer
// passes the input register and then the result register around the lane logic.
// Reset clears both valid flags; payload registers are not reset.
// While m_axis_tready is low the result holds; a new input is still taken
// whenever the input register is empty or moving on.
module mu_law_codec_eight_lane_core
    import mlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // lane_in_0 .. lane_in_7, 16 bits each
    input  logic              s_axis_tuser,   // mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata    // lane_out_0 .. lane_out_7, 16 bits each
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_mode_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] result;
    logic              advance_out;

    assign advance_out   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance_out;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = advance_out ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
        if (in_valid_reg && advance_out)
        begin
            out_data_reg <= result;
        end
    end

    for (genvar k = 0; k < NUM_LANE_FIELDS; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_used
            mlc_lane u_lane
            (
                .mode (in_mode_reg),
                .din  (in_data_reg[k*LANE_W +: LANE_W]),
                .dout (result[k*LANE_W +: LANE_W])
            );
        end
        else
        begin : g_unused
            assign result[k*LANE_W +: LANE_W] = '0;
        end
    end

endmodule

@@ hw/rtl/mlc_checker.sv @@
// Port-level checks of the codec top level, bound into it.
`include "mu_law_codec_eight_lane_core_macros.svh"

module mlc_checker
    import mlc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    logic in_xfer;
    logic upper_clear;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        upper_clear = 1'b1;
        for (int k = 0; k < NUM_LANE_FIELDS; k++)
        begin
            if (m_axis_tdata[k*LANE_W+CODE_W +: (LANE_W-CODE_W)] != '0)
            begin
                upper_clear = 1'b0;
            end
        end
    end

    `MLC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |-> !m_axis_tvalid, "output valid in reset")
    `MLC_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
    `MLC_ASSERT(a_two_cycle_latency, in_xfer ##1 m_axis_tready |=> m_axis_tvalid, "result missing after two cycles")
    `MLC_ASSERT(a_code_upper_zero, (in_xfer && s_axis_tuser == MODE_COMPRESS) ##1 m_axis_tready |=> upper_clear, "code byte not zero-extended")
    `MLC_ASSERT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind mu_law_codec_eight_lane_core mlc_checker u_checker (.*);

@@ dv/mlc_codec_checker.sv @@
// Codec checker: predicts every lane of each transfer and compares the results in order.
module mlc_codec_checker
    import mlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [DATA_W-1:0] m_tdata,
    output int                mismatches,
    output int                outstanding,
    output int                compress_seen,
    output int                decompress_seen,
    output int                results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    logic [DATA_W-1:0] expected_words [$];
    logic [DATA_W-1:0] want;
    lane_word_t        want_lane;
    lane_word_t        got_lane;

    initial
    begin
        mismatches      = 0;
        outstanding     = 0;
        compress_seen   = 0;
        decompress_seen = 0;
        results_checked = 0;
    end

    function automatic lane_word_t encode_sample(lane_word_t sample);
        logic             neg;
        logic [LANE_W-1:0] mag_full;
        logic [MAG_W-1:0]  mag;
        logic [MAG_W-1:0]  q;
        logic [SEG_W-1:0]  seg;
        int                lead;
        int                shift;
        neg      = sample[LANE_W-1];
        mag_full = neg ? (~sample + 1'b1) : sample;
        // -32768 wraps to 0x8000 here and is clamped
        mag      = (mag_full > MAG_MAX) ? MAG_MAX : mag_full[MAG_W-1:0];
        lead     = -1;
        for (int i = 0; i < MAG_W; i++)
            if (mag[i])
                lead = i;
        if (lead >= CODE_W)
        begin
            shift = lead - MANT_W;
            seg   = SEG_W'(lead - (CODE_W - 1));
        end
        else
        begin
            shift = MANT_W;
            seg   = '0;
        end
        q = mag >> shift;
        if (q <= ZERO_LIMIT)
            return lane_word_t'(ZERO_BYTE);
        return lane_word_t'({neg, seg, q[MANT_W-1:0]});
    endfunction

    function automatic lane_word_t decode_code(lane_word_t word);
        code_t             c;
        logic [SEG_W-1:0]  seg;
        logic [LANE_W-1:0] mag;
        c = word[CODE_W-1:0];
        if (c == ZERO_BYTE)
            return '0;
        seg = c[MANT_W +: SEG_W];
        mag = (LANE_W'(c[MANT_W-1:0]) * LANE_W'(8) + LANE_W'(BIAS)) << seg;
        return c[CODE_W-1] ? (~mag + 1'b1) : mag;
    endfunction

    function automatic logic [DATA_W-1:0] predict_lanes(logic mode, logic [DATA_W-1:0] words);
        logic [DATA_W-1:0] result;
        result = '0;
        for (int k = 0; k < NUM_LANE_FIELDS; k++)
            if (k < LANES)
                result[k*LANE_W +: LANE_W] = (mode == MODE_DECOMPRESS) ?
                    decode_code(words[k*LANE_W +: LANE_W]) :
                    encode_sample(words[k*LANE_W +: LANE_W]);
        return result;
    endfunction

    task automatic report_mismatch(input string detail);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, detail);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
                else
                begin
                    want = expected_words.pop_front();
                    for (int k = 0; k < NUM_LANE_FIELDS; k++)
                    begin
                        want_lane = want[k*LANE_W +: LANE_W];
                        got_lane  = m_tdata[k*LANE_W +: LANE_W];
                        if (got_lane !== want_lane)
                            report_mismatch($sformatf("result %0d lane %0d expected %h got %h",
                                                      results_checked, k, want_lane, got_lane));
                    end
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_words.push_back(predict_lanes(s_tuser, s_tdata));
                if (s_tuser == MODE_DECOMPRESS)
                    decompress_seen++;
                else
                    compress_seen++;
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

@@ dv/mu_law_codec_eight_lane_core_test.sv @@
// Testbench top for the eight-lane mu-law codec: stimulus, flow control and verdict.
module mu_law_codec_eight_lane_core_test;
    import mlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1800;
    localparam int DIRECTED_N   = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int IDLE_PCT     = 22;

    typedef lane_word_t lane_set_t [NUM_LANE_FIELDS];

    logic              clk = 1'b0;
    logic              rst_n = 1'b1;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = MODE_COMPRESS;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int compress_seen;
    int decompress_seen;
    int results_checked;

    int   tx_idle_pct = IDLE_PCT;
    int   rx_idle_pct = IDLE_PCT;
    logic hold_request = 1'b0;
    int   hold_offs = 0;
    int   drain_pauses = 0;

    mu_law_codec_eight_lane_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mlc_codec_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .compress_seen   (compress_seen),
        .decompress_seen (decompress_seen),
        .results_checked (results_checked)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: random back-pressure, or a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                hold_offs++;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [DATA_W-1:0] pack_lanes(lane_set_t set);
        logic [DATA_W-1:0] words;
        for (int k = 0; k < NUM_LANE_FIELDS; k++)
            words[k*LANE_W +: LANE_W] = set[k];
        return words;
    endfunction

    function automatic lane_word_t random_sample();
        lane_word_t v;
        int         pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: v = lane_word_t'($urandom);
            4, 5:       v = lane_word_t'($urandom_range(511));
            6, 7:       v = lane_word_t'($urandom >> $urandom_range(17, 31));
            8:          v = lane_word_t'($urandom_range(230, 250));
            default:
            begin
                case ($urandom_range(3))
                    0:       v = 16'h8000;
                    1:       v = 16'h8001;
                    2:       v = 16'h7FFF;
                    default: v = '0;
                endcase
            end
        endcase
        if (pick >= 4 && pick <= 8 && $urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic lane_word_t random_code();
        lane_word_t v;
        v = lane_word_t'($urandom);
        if ($urandom_range(7) == 0)
            v[CODE_W-1:0] = ZERO_BYTE;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] random_payload(logic mode);
        lane_set_t set;
        for (int k = 0; k < NUM_LANE_FIELDS; k++)
            set[k] = (mode == MODE_DECOMPRESS) ? random_code() : random_sample();
        return pack_lanes(set);
    endfunction

    task automatic offer_item(input logic mode, input logic [DATA_W-1:0] payload);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        drain_pauses++;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    initial
    begin
        lane_set_t directed_sets [DIRECTED_N];
        logic      directed_modes [DIRECTED_N];
        logic      mode;
        int        waited;

        directed_sets = '{
            '{0, 1, -1, 239, 240, -240, -239, 255},
            '{256, 32767, -32768, -32767, 16384, -16384, 8191, -8192},
            '{511, 512, 1023, 1024, 2047, 2048, 4095, 4096},
            '{-511, -512, -1023, -1024, 16'h7F00, 16'h00FF, -255, -256},
            '{16'h0000, 16'h000F, 16'h0070, 16'h007F, 16'h0080, 16'h008F, 16'h00F7, 16'h00FF},
            '{16'hFFFF, 16'hAB00, 16'h55F0, 16'h807E, 16'hFF7F, 16'h0180, 16'h7F0F, 16'hC3FE},
            '{16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h0050, 16'h0060, 16'h00FE, 16'h00F0},
            '{16'h0090, 16'h00A5, 16'h00B3, 16'h00C8, 16'h00D1, 16'h00E6, 16'h00EF, 16'h0001}
        };
        directed_modes = '{MODE_COMPRESS, MODE_COMPRESS, MODE_COMPRESS, MODE_COMPRESS,
                           MODE_DECOMPRESS, MODE_DECOMPRESS, MODE_DECOMPRESS,
                           MODE_DECOMPRESS};

        // falling edge before the first clock so the asynchronous reset takes hold
        #1 rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            offer_item(directed_modes[i], pack_lanes(directed_sets[i]));
        pause_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 600)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 900)
            begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (i == 300 || i == 1200)
                hold_request = 1'b1;
            if (i == 1000)
                pause_until_drained();
            mode = $urandom_range(1) ? MODE_DECOMPRESS : MODE_COMPRESS;
            offer_item(mode, random_payload(mode));
        end

        s_axis_tvalid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < DRAIN_LIMIT);
        repeat (8) @(posedge clk);

        $display("Covered %0d compress and %0d decompress transfers, %0d results checked",
                 compress_seen, decompress_seen, results_checked);
        $display("Receiver hold-offs %0d, drain pauses %0d, mismatches %0d, still owed %0d",
                 hold_offs, drain_pauses, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
